@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the RTL, included by the line substring filter.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (conseq)) \
        else $error("assertion failed: same-cycle implication");

// The consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conseq)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/lsf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line substring filter package
// Register indexes, character constants, the result word type and the
// ASCII case folding helper.
// ----------------------------------------------------------------------------
package lsf_pkg;

    typedef enum logic [2:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_PATTERN_LEN  = 3'd2,
        REG_IGNORE_CASE  = 3'd3,
        REG_INVERT_MATCH = 3'd4
    } lsf_reg_t;

    localparam logic [7:0] ASCII_NUL      = 8'h00;
    localparam logic [7:0] ASCII_NEWLINE  = 8'h0A;
    localparam logic [7:0] ASCII_UPPER_A  = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z  = 8'h5A;
    localparam logic [7:0] ASCII_CASE_GAP = 8'h20;

    localparam int unsigned PATTERN_SLOTS = 16;
    localparam int unsigned OUT_FIELD_W   = 32;

    typedef struct packed {
        logic [OUT_FIELD_W-1:0] line_index;
        logic                   line_selected;
        logic [OUT_FIELD_W-1:0] selected_count;
        logic                   file_done;
    } lsf_result_t;

    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_en);
        logic [7:0] r;
        r = c;
        if (fold_en && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            r = c + ASCII_CASE_GAP;
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/line_substring_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line substring filter
// Scans a byte stream and reports, for every closed line, its number, whether
// it contains the configured pattern (optionally case folded and inverted),
// and the running selected count of the file.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  s_axis    in         tdata[7:0] data_byte, tlast end_of_file
//  m_axis    out        tdata[31:0] line_index, tdata[63:32] selected_count,
//                       tuser[0] line_selected, tlast file_done
//  apb       in/out     64-bit registers at byte addresses 0, 8, 16, 24, 32
//
// One byte is taken per cycle while s_tready is high; result words are registered.
// The window compare and counter update sit between the line state registers.
// A two-entry output stage lets input flow on for one stalled result word.
// Reset is synchronous and active low; it clears config, counters and line flags.
// ----------------------------------------------------------------------------
module line_substring_filter #(
    parameter int PATTERN_MAX = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] line_index, [63:32] selected_count
    output logic [0:0]  m_tuser,   // [0] line_selected
    output logic        m_tlast
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int PIDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

    // Configuration registers.
    logic [63:0] pat_low_reg;
    logic [63:0] pat_high_reg;
    logic [4:0]  pat_len_reg;
    logic        ignore_case_reg;
    logic        invert_reg;

    // Line state.
    logic [7:0]             win_reg [PATTERN_MAX];
    logic [7:0]             win_next [PATTERN_MAX];
    logic [LEN_W-1:0]       fill_reg;
    logic [LEN_W-1:0]       fill_next;
    logic                   match_reg;
    logic                   match_next;
    logic                   zero_reg;
    logic                   zero_next;
    logic [COUNT_WIDTH-1:0] line_cnt_reg;
    logic [COUNT_WIDTH-1:0] sel_cnt_reg;
    logic [COUNT_WIDTH-1:0] line_cnt_inc;
    logic [COUNT_WIDTH-1:0] sel_cnt_inc;
    logic                   selected;
    logic                   line_close;

    // Output stage.
    lsf_pkg::lsf_result_t out_reg;
    lsf_pkg::lsf_result_t skid_reg;
    lsf_pkg::lsf_result_t result;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;

    logic [7:0]       pat_fold [PATTERN_MAX];
    logic [127:0]     pat_all;
    logic [4:0]       len_clip;
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W:0]   win_off;
    logic [LEN_W:0]   pidx_wide;
    logic             win_hit;

    logic        cfg_write;
    lsf_pkg::lsf_reg_t cfg_sel;
    logic        in_fire;
    logic [7:0]  in_byte;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_sel   = lsf_pkg::lsf_reg_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg     <= '0;
            pat_high_reg    <= '0;
            pat_len_reg     <= '0;
            ignore_case_reg <= 1'b0;
            invert_reg      <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                lsf_pkg::REG_PATTERN_LOW:  pat_low_reg     <= pwdata;
                lsf_pkg::REG_PATTERN_HIGH: pat_high_reg    <= pwdata;
                lsf_pkg::REG_PATTERN_LEN:  pat_len_reg     <= pwdata[4:0];
                lsf_pkg::REG_IGNORE_CASE:  ignore_case_reg <= pwdata[0];
                lsf_pkg::REG_INVERT_MATCH: invert_reg      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            lsf_pkg::REG_PATTERN_LOW:  prdata = pat_low_reg;
            lsf_pkg::REG_PATTERN_HIGH: prdata = pat_high_reg;
            lsf_pkg::REG_PATTERN_LEN:  prdata = {59'd0, pat_len_reg};
            lsf_pkg::REG_IGNORE_CASE:  prdata = {63'd0, ignore_case_reg};
            lsf_pkg::REG_INVERT_MATCH: prdata = {63'd0, invert_reg};
            default:                   prdata = '0;
        endcase
    end

    // The pattern ends at the clipped length or at its first zero byte.
    always_comb begin
        pat_all  = {pat_high_reg, pat_low_reg};
        len_clip = (pat_len_reg > 5'(PATTERN_MAX)) ? 5'(PATTERN_MAX) : pat_len_reg;
        eff_len  = LEN_W'(len_clip);
        for (int i = PATTERN_MAX - 1; i >= 0; i--) begin
            pat_fold[i] = lsf_pkg::fold_byte(pat_all[8*i +: 8], ignore_case_reg);
            if (5'(i) < len_clip && pat_all[8*i +: 8] == lsf_pkg::ASCII_NUL) begin
                eff_len = LEN_W'(i);
            end
        end
    end

    assign s_tready = ~skid_valid_reg;
    assign in_fire  = s_tvalid & s_tready;
    assign in_byte  = s_tdata;

    always_comb begin
        zero_next = zero_reg | (in_byte == lsf_pkg::ASCII_NUL);
        fill_next = fill_reg;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            win_next[k] = win_reg[k];
        end
        if (!zero_next) begin
            for (int k = 0; k < PATTERN_MAX - 1; k++) begin
                win_next[k] = win_reg[k + 1];
            end
            win_next[PATTERN_MAX-1] = in_byte;
            if (fill_reg < LEN_MAX) begin
                fill_next = fill_reg + 1'b1;
            end
        end

        // The newest eff_len window bytes line up with the pattern.
        win_off = (LEN_W+1)'(PATTERN_MAX) - {1'b0, eff_len};
        win_hit = (fill_next >= eff_len);
        for (int k = 0; k < PATTERN_MAX; k++) begin
            pidx_wide = (LEN_W+1)'(k) - win_off;
            if ((LEN_W+1)'(k) >= win_off) begin
                if (lsf_pkg::fold_byte(win_next[k], ignore_case_reg)
                        != pat_fold[pidx_wide[PIDX_W-1:0]]) begin
                    win_hit = 1'b0;
                end
            end
        end
        match_next = match_reg | (eff_len == '0) | win_hit;

        line_close   = (in_byte == lsf_pkg::ASCII_NEWLINE) | s_tlast;
        line_cnt_inc = (line_cnt_reg == '1) ? line_cnt_reg : line_cnt_reg + 1'b1;
        selected     = match_next ^ invert_reg;
        sel_cnt_inc  = (selected && sel_cnt_reg != '1) ? sel_cnt_reg + 1'b1 : sel_cnt_reg;

        result.line_index     = lsf_pkg::OUT_FIELD_W'(line_cnt_inc);
        result.line_selected  = selected;
        result.selected_count = lsf_pkg::OUT_FIELD_W'(sel_cnt_inc);
        result.file_done      = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int k = 0; k < PATTERN_MAX; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            match_reg    <= 1'b0;
            zero_reg     <= 1'b0;
            line_cnt_reg <= '0;
            sel_cnt_reg  <= '0;
        end else if (in_fire) begin
            if (line_close) begin
                fill_reg  <= '0;
                match_reg <= 1'b0;
                zero_reg  <= 1'b0;
                if (s_tlast) begin
                    line_cnt_reg <= '0;
                    sel_cnt_reg  <= '0;
                end else begin
                    line_cnt_reg <= line_cnt_inc;
                    sel_cnt_reg  <= sel_cnt_inc;
                end
            end else begin
                fill_reg  <= fill_next;
                match_reg <= match_next;
                zero_reg  <= zero_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg | (in_fire & line_close);
            skid_valid_reg <= 1'b0;
        end else if (in_fire && line_close) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end else if (in_fire && line_close) begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.selected_count, out_reg.line_index};
    assign m_tuser  = out_reg.line_selected;
    assign m_tlast  = out_reg.file_done;

`include "assert_macros.svh"

    `ASSERT_SAME(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `ASSERT_SAME(a_sel_below_line, aclk, aresetn, 1'b1, sel_cnt_reg <= line_cnt_reg)
    `ASSERT_NEXT(a_eof_clears_counts, aclk, aresetn, in_fire && s_tlast,
                 line_cnt_reg == '0 && sel_cnt_reg == '0 && fill_reg == '0)

endmodule

@@ tb/lsf_line_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line substring filter checker
// Watches the register port and both stream channels of the filter. It keeps
// its own copy of the pattern registers and the line state, works out the
// result word of every line that an accepted byte closes, and compares each
// result word leaving the block with the oldest one still waiting.
// ----------------------------------------------------------------------------
module lsf_line_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // [31:0] line_index, [63:32] selected_count
    input  logic [0:0]  m_tuser,   // [0] line_selected
    input  logic        m_tlast,

    output int unsigned failures,
    output int unsigned outstanding
);

    logic [7:0]  window [lsf_pkg::PATTERN_SLOTS];
    int unsigned fill;
    logic        hit;
    logic        nul_seen;
    logic [31:0] line_no;
    logic [31:0] sel_no;

    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [4:0]  pat_len;
    logic        fold_on;
    logic        invert_on;

    lsf_pkg::lsf_result_t expected_lines [$];
    int unsigned errors;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (fold_on && c >= lsf_pkg::ASCII_UPPER_A && c <= lsf_pkg::ASCII_UPPER_Z) begin
            return c ^ lsf_pkg::ASCII_CASE_GAP;
        end
        return c;
    endfunction

    function automatic logic [7:0] pat_byte(input int unsigned i);
        return (i < 8) ? pat_lo[i*8 +: 8] : pat_hi[(i-8)*8 +: 8];
    endfunction

    function automatic void clear_line();
        for (int i = 0; i < lsf_pkg::PATTERN_SLOTS; i++) begin
            window[i] = '0;
        end
        fill = 0;
        hit = 1'b0;
        nul_seen = 1'b0;
    endfunction

    // Advances the line state by one byte; returns 1 when the byte closes a line.
    function automatic logic scan_byte(input logic [7:0] b, input logic eof,
                                       output lsf_pkg::lsf_result_t res);
        int unsigned cap;
        int unsigned len;
        logic        ok;
        res = '0;
        cap = (pat_len > lsf_pkg::PATTERN_SLOTS) ? lsf_pkg::PATTERN_SLOTS : pat_len;
        len = 0;
        while (len < cap && pat_byte(len) != lsf_pkg::ASCII_NUL) begin
            len++;
        end
        if (b == lsf_pkg::ASCII_NUL) begin
            nul_seen = 1'b1;
        end
        if (!nul_seen) begin
            for (int i = 0; i < lsf_pkg::PATTERN_SLOTS - 1; i++) begin
                window[i] = window[i+1];
            end
            window[lsf_pkg::PATTERN_SLOTS-1] = b;
            if (fill < lsf_pkg::PATTERN_SLOTS) begin
                fill++;
            end
        end
        ok = (fill >= len);
        for (int i = 0; i < len; i++) begin
            if (to_lower(window[lsf_pkg::PATTERN_SLOTS-len+i]) != to_lower(pat_byte(i))) begin
                ok = 1'b0;
            end
        end
        if (ok) begin
            hit = 1'b1;
        end
        if (b != lsf_pkg::ASCII_NEWLINE && !eof) begin
            return 1'b0;
        end
        if (line_no != '1) begin
            line_no++;
        end
        res.line_selected = hit ^ invert_on;
        if (res.line_selected && sel_no != '1) begin
            sel_no++;
        end
        res.line_index = line_no;
        res.selected_count = sel_no;
        res.file_done = eof;
        clear_line();
        if (eof) begin
            line_no = '0;
            sel_no = '0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : monitor
        lsf_pkg::lsf_result_t got;
        lsf_pkg::lsf_result_t want;
        if (!aresetn) begin
            clear_line();
            line_no = '0;
            sel_no = '0;
            pat_lo = '0;
            pat_hi = '0;
            pat_len = '0;
            fold_on = 1'b0;
            invert_on = 1'b0;
            expected_lines.delete();
            errors = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.line_index = m_tdata[31:0];
                got.selected_count = m_tdata[63:32];
                got.line_selected = m_tuser[0];
                got.file_done = m_tlast;
                if (expected_lines.size() == 0) begin
                    $error("unexpected result word, line_index %0d", got.line_index);
                    errors++;
                end else begin
                    want = expected_lines.pop_front();
                    if (got.line_index !== want.line_index) begin
                        $error("line_index expected %0d, got %0d",
                               want.line_index, got.line_index);
                        errors++;
                    end
                    if (got.line_selected !== want.line_selected) begin
                        $error("line_selected expected %0d, got %0d",
                               want.line_selected, got.line_selected);
                        errors++;
                    end
                    if (got.selected_count !== want.selected_count) begin
                        $error("selected_count expected %0d, got %0d",
                               want.selected_count, got.selected_count);
                        errors++;
                    end
                    if (got.file_done !== want.file_done) begin
                        $error("file_done expected %0d, got %0d",
                               want.file_done, got.file_done);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (scan_byte(s_tdata, s_tlast, want)) begin
                    expected_lines.push_back(want);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (lsf_pkg::lsf_reg_t'(paddr[5:3]))
                    lsf_pkg::REG_PATTERN_LOW: begin
                        pat_lo = pwdata;
                    end
                    lsf_pkg::REG_PATTERN_HIGH: begin
                        pat_hi = pwdata;
                    end
                    lsf_pkg::REG_PATTERN_LEN: begin
                        pat_len = pwdata[4:0];
                    end
                    lsf_pkg::REG_IGNORE_CASE: begin
                        fold_on = pwdata[0];
                    end
                    lsf_pkg::REG_INVERT_MATCH: begin
                        invert_on = pwdata[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        failures <= errors;
        outstanding <= expected_lines.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line substring filter testbench
// Programs the pattern registers between phases and streams text through the
// filter: first a few hand-written lines covering case folding, inversion,
// empty and zero-terminated patterns, over-long lengths, zero bytes in the
// text and file ends, then random lines built around the current pattern.
// Random phases may stall either channel in random bursts; the checker predicts every word.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned ITEM_TARGET = 2000;
    localparam int unsigned TAIL_ITEMS  = 250;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned CYCLE_LIMIT = 500000;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [31:0] line_index, [63:32] selected_count
    logic [0:0]  m_tuser;   // [0] line_selected
    logic        m_tlast;

    int unsigned failures;
    int unsigned outstanding;
    int unsigned cycles;
    int unsigned sent;
    int unsigned gap_odds;
    int unsigned stall_odds;
    logic [7:0]  pat [lsf_pkg::PATTERN_SLOTS];
    int unsigned pat_used;

    line_substring_filter dut (.*);
    lsf_line_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always begin
        @(posedge aclk);
        if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        m_tready <= 1'b1;
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eof;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic end_phase();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input lsf_pkg::lsf_reg_t idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] len, input logic fold, input logic inv);
        write_reg(lsf_pkg::REG_PATTERN_LOW, lo);
        write_reg(lsf_pkg::REG_PATTERN_HIGH, hi);
        write_reg(lsf_pkg::REG_PATTERN_LEN, 64'(len));
        write_reg(lsf_pkg::REG_IGNORE_CASE, 64'(fold));
        write_reg(lsf_pkg::REG_INVERT_MATCH, 64'(inv));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        for (int i = 0; i < 8; i++) begin
            pat[i] = lo[i*8 +: 8];
            pat[i+8] = hi[i*8 +: 8];
        end
        pat_used = (len > lsf_pkg::PATTERN_SLOTS) ? lsf_pkg::PATTERN_SLOTS : len;
    endtask

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 1) == 1) begin
            return 8'(lsf_pkg::ASCII_UPPER_A + $urandom_range(0, 2));
        end
        return 8'(lsf_pkg::ASCII_UPPER_A + lsf_pkg::ASCII_CASE_GAP + $urandom_range(0, 2));
    endfunction

    function automatic logic [7:0] pattern_char();
        case ($urandom_range(0, 19))
            0: return lsf_pkg::ASCII_NUL;
            1, 2: return 8'($urandom_range(0, 255));
            default: return text_char();
        endcase
    endfunction

    task automatic random_phase();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [7:0]  b;
        logic [7:0]  up;
        logic        quiet;
        int          budget;
        int unsigned pick;
        for (int i = 0; i < 8; i++) begin
            lo[i*8 +: 8] = pattern_char();
            hi[i*8 +: 8] = pattern_char();
        end
        case ($urandom_range(0, 9))
            0: len = '0;
            1: len = 5'($urandom_range(lsf_pkg::PATTERN_SLOTS + 1, 31));
            2: len = 5'(lsf_pkg::PATTERN_SLOTS);
            3: len = 5'($urandom_range(5, lsf_pkg::PATTERN_SLOTS - 1));
            default: len = 5'($urandom_range(1, 4));
        endcase
        set_config(lo, hi, len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        quiet = (sent + TAIL_ITEMS >= ITEM_TARGET);
        case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 2;
            default: gap_odds = 6;
        endcase
        if (quiet) begin
            gap_odds = 0;
        end
        stall_odds <= quiet ? 0 : $urandom_range(0, 2) * 3;
        budget = $urandom_range(10, 150);
        while (budget > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 14) begin
                for (int i = 0; i < pat_used; i++) begin
                    b = pat[i];
                    up = b & ~lsf_pkg::ASCII_CASE_GAP;
                    if (up >= lsf_pkg::ASCII_UPPER_A && up <= lsf_pkg::ASCII_UPPER_Z
                            && $urandom_range(0, 3) == 0) begin
                        b = b ^ lsf_pkg::ASCII_CASE_GAP;
                    end
                    send_byte(b, 1'b0);
                end
                budget -= pat_used + 1;
            end else begin
                if (pick < 26) begin
                    b = lsf_pkg::ASCII_NEWLINE;
                end else if (pick < 28) begin
                    b = lsf_pkg::ASCII_NUL;
                end else if (pick < 35) begin
                    b = 8'($urandom_range(0, 255));
                end else begin
                    b = text_char();
                end
                send_byte(b, $urandom_range(0, 39) == 0);
                budget--;
            end
        end
        end_phase();
    endtask

    initial begin
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        m_tready <= 1'b0;
        cycles <= 0;
        stall_odds <= 0;
        gap_odds = 0;
        sent = 0;
        pat_used = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Folded two-byte pattern, a zero byte hiding a match, file end on a plain byte.
        set_config(64'h4261, 64'h0, 5'd2, 1'b1, 1'b0);
        send_byte("x", 1'b0);
        send_byte("A", 1'b0);
        send_byte("b", 1'b0);
        send_byte(lsf_pkg::ASCII_NEWLINE, 1'b0);
        send_byte("q", 1'b0);
        send_byte(lsf_pkg::ASCII_NUL, 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b0);
        send_byte(lsf_pkg::ASCII_NEWLINE, 1'b0);
        send_byte("a", 1'b0);
        send_byte("b", 1'b1);
        end_phase();

        // Empty pattern with inverted selection; newlines that also end the file.
        set_config(64'h0, '1, 5'd0, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(lsf_pkg::ASCII_NEWLINE, 1'b1);
        send_byte(lsf_pkg::ASCII_NEWLINE, 1'b1);
        end_phase();

        // Length beyond the window, cut short by a zero byte in the pattern.
        set_config(64'hFFFF_FFFF_FFFF_007A, '1, 5'd31, 1'b0, 1'b0);
        send_byte("z", 1'b0);
        send_byte(lsf_pkg::ASCII_NEWLINE, 1'b0);
        send_byte("Z", 1'b1);
        end_phase();

        while (sent < ITEM_TARGET) begin
            random_phase();
        end
        end_phase();

        if (failures == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lsf_pkg.sv
hw/rtl/line_substring_filter.sv
tb/lsf_line_checker.sv
tb/tb.sv
